### rtl/rpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpf_pkg;

  localparam int RPF_MAX_WIDTH = 64;

  localparam int CH_W    = 8;
  localparam int WIDTH_W = 7;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W  = 24;

  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY   = 2'd0,
    MODE_INV    = 2'd1,
    MODE_MIRROR = 2'd2,
    MODE_MIRROR_ALT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDX_MODE  = 2'd0,
    CFG_IDX_WIDTH = 2'd1,
    CFG_IDX_RSVD2 = 2'd2,
    CFG_IDX_RSVD3 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            row_end;
  } pix_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAY,
    ST_INV,
    ST_RD,
    ST_MOV
  } state_t;

endpackage
`default_nettype wire

### rtl/row_pixel_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// grayscale words reach the output register via the luma product registers, invert words
//   via pix_r; grayscale and invert take no new word until the last one is loaded there
// mirror takes one word per cycle until a row ends, then drains the row, each word taking
//   one row-buffer read and one output load; the registered read port sets the drain rate
// reset: mode grayscale, row width 64, column counter zero; the row buffer is not cleared
module row_pixel_filter
  import rpf_pkg::*;
#(
  parameter int MAX_WIDTH = RPF_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pix_in_t               in_data,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pix_out_t                   out_data,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  mode_t               mode_r;
  logic [WIDTH_W-1:0]  row_width_r;

  // row tracking and per-word context
  logic [AW-1:0]       col_r;
  logic [AW-1:0]       idx_r;
  logic                last_r;
  pix_in_t             pix_r;

  state_t              state_r;
  state_t              state_nxt;

  // output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  pix_out_t            out_data_r;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  pix_out_t            out_word;
  logic                is_mirror;
  logic [WIDTH_W-1:0]  wid_eff;
  logic [WIDTH_W-1:0]  col_p1;
  logic                last;
  logic [CH_W-1:0]     luma;
  pix_in_t             rd_pix;

  // config writes are always taken; the user must issue them only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GRAY;
      row_width_r <= WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IDX_MODE:  mode_r      <= mode_t'(cfg_data[MODE_W-1:0]);
        CFG_IDX_WIDTH: row_width_r <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // mode three folds into mirror
  assign is_mirror = (mode_r != MODE_GRAY) && (mode_r != MODE_INV);

  // zero width acts as one, anything above the buffer depth saturates
  always_comb begin
    if (row_width_r == '0) begin
      wid_eff = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_W'(MAX_WIDTH)) begin
      wid_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      wid_eff = row_width_r;
    end
  end

  assign col_p1 = WIDTH_W'(col_r) + WIDTH_W'(1);
  assign last   = (col_p1 >= wid_eff);

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // every word lands in the row buffer whatever the mode
  rpf_row_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_row_mem (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (in_data),
    .raddr (idx_r),
    .rdata (rd_pix)
  );

  rpf_luma u_luma (
    .clk  (clk),
    .load (in_acc),
    .pix  (in_data),
    .luma (luma)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_r == MODE_GRAY) begin
            state_nxt = ST_GRAY;
          end else if (mode_r == MODE_INV) begin
            state_nxt = ST_INV;
          end else if (is_mirror && last) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_GRAY, ST_INV: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_MOV;
      end
      ST_MOV: begin
        if (out_free) begin
          state_nxt = (idx_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    out_word = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_GRAY: begin
        out_load           = out_free;
        out_word.out_red   = luma;
        out_word.out_green = luma;
        out_word.out_blue  = luma;
        out_word.row_end   = last_r;
      end
      ST_INV: begin
        out_load           = out_free;
        out_word.out_red   = CH_MAX - pix_r.red;
        out_word.out_green = CH_MAX - pix_r.green;
        out_word.out_blue  = CH_MAX - pix_r.blue;
        out_word.row_end   = last_r;
      end
      ST_MOV: begin
        // read data for idx_r is held since raddr stays put
        out_load           = out_free;
        out_word.out_red   = rd_pix.red;
        out_word.out_green = rd_pix.green;
        out_word.out_blue  = rd_pix.blue;
        out_word.row_end   = (idx_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        col_r <= last ? '0 : AW'(col_p1);
      end
    end
  end

  // per-word context and mirror read pointer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r  <= in_data;
      last_r <= last;
      // drain starts at the word just stored
      idx_r  <= col_r;
    end else if (state_r == ST_MOV && out_free && idx_r != '0) begin
      idx_r <= idx_r - AW'(1);
    end
  end

  // output register: takes a word when empty or being drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/rpf_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module rpf_row_mem
  import rpf_pkg::*;
#(
  parameter int DEPTH = RPF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pix_in_t       wdata,
  input  wire logic [AW-1:0] raddr,
  output pix_in_t            rdata
);

  pix_in_t mem [DEPTH];
  pix_in_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/rpf_luma.sv
`timescale 1ns / 1ps
`default_nettype none
module rpf_luma
  import rpf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            load,
  input  wire pix_in_t         pix,
  output logic [CH_W-1:0]      luma
);

  // weighted products, one register stage ahead of the sum
  logic [PROD_W-1:0] prod_r_r;
  logic [PROD_W-1:0] prod_g_r;
  logic [PROD_W-1:0] prod_b_r;
  logic [PROD_W:0]   sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r_r <= PROD_W'(pix.red)   * PROD_W'(W_RED);
      prod_g_r <= PROD_W'(pix.green) * PROD_W'(W_GREEN);
      prod_b_r <= PROD_W'(pix.blue)  * PROD_W'(W_BLUE);
    end
  end

  // weights sum to 65536, so the total stays below 2^24
  assign sum  = {1'b0, prod_r_r} + {1'b0, prod_g_r} + {1'b0, prod_b_r};
  assign luma = sum[PROD_W-1:16];

endmodule
`default_nettype wire
